// ===== rtl/distance_route_table_unit_defines.svh =====
// Assertion macros shared by the route table checker.
// No dependencies; include by bare file name.
`ifndef DISTANCE_ROUTE_TABLE_UNIT_DEFINES_SVH
`define DISTANCE_ROUTE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("route table check failed");

// Next-cycle implication, disabled during reset.
`define DRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route table check failed");

`endif

// ===== rtl/drt_pkg.sv =====
// Types and constants of the distance route table.
// No dependencies; used by the interface, the scan unit and the top level.
package drt_pkg;

  localparam int unsigned DRT_ENTRIES = 16;
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [DIST_W-1:0] DIST_MAX              = '1;
  localparam logic [TIME_W-1:0] ROUTE_TIMEOUT_DEFAULT = 32'd1000000;

  // Action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_WEIGHT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_TIMEOUT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [DIST_W-1:0] offered_distance;
    logic [TIME_W-1:0] time_now;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] distance;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DIST_W-1:0] distance;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Scan summary handed from the scan unit to the sequencer
  typedef struct packed {
    logic              hit;
    logic              free_found;
    logic [DIST_W-1:0] hit_dist;
    logic [TIME_W-1:0] hit_stamp;
  } scan_t;

endpackage

// ===== rtl/drt_stream_if.sv =====
// Valid/ready stream channel carrying one item of type T.
// Depends on drt_pkg for the default payload type.
interface drt_stream_if #(
  parameter type T = drt_pkg::req_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/drt_scan_unit.sv =====
// Compare unit of the route table: one entry per step, tracks match, free and oldest.
// Depends on drt_pkg.
module drt_scan_unit #(
  parameter int unsigned IdxW = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      step_i,
  input  logic [IdxW-1:0]           idx_i,
  input  logic                      ent_vld_i,
  input  drt_pkg::entry_t           ent_i,
  input  logic [drt_pkg::ADDR_W-1:0] key_i,
  output drt_pkg::scan_t            res_o,
  output logic [IdxW-1:0]           hit_idx_o,
  output logic [IdxW-1:0]           free_idx_o,
  output logic [IdxW-1:0]           old_idx_o
);
  import drt_pkg::*;

  scan_t             res_q;
  logic              old_set_q;
  logic [TIME_W-1:0] old_stamp_q;
  logic [IdxW-1:0]   hit_idx_q;
  logic [IdxW-1:0]   free_idx_q;
  logic [IdxW-1:0]   old_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= '0;
      old_set_q   <= 1'b0;
      old_stamp_q <= '0;
      hit_idx_q   <= '0;
      free_idx_q  <= '0;
      old_idx_q   <= '0;
    end else if (clear_i) begin
      res_q.hit        <= 1'b0;
      res_q.free_found <= 1'b0;
      old_set_q        <= 1'b0;
    end else if (step_i) begin
      if (ent_vld_i) begin
        if (!res_q.hit && (ent_i.address == key_i)) begin
          res_q.hit       <= 1'b1;
          res_q.hit_dist  <= ent_i.distance;
          res_q.hit_stamp <= ent_i.stamp;
          hit_idx_q       <= idx_i;
        end
        // strict compare keeps the lowest index on ties
        if (!old_set_q || (ent_i.stamp < old_stamp_q)) begin
          old_set_q   <= 1'b1;
          old_stamp_q <= ent_i.stamp;
          old_idx_q   <= idx_i;
        end
      end else if (!res_q.free_found) begin
        res_q.free_found <= 1'b1;
        free_idx_q       <= idx_i;
      end
    end
  end

  assign res_o      = res_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign old_idx_o  = old_idx_q;

endmodule

// ===== rtl/distance_route_table_unit.sv =====
// Distance route table: Entries routes of {48-bit address, 16-bit distance, 32-bit
// timestamp} in a memory with one write and one read port, and a valid bit per entry in
// flip-flops that reset clears, so no clearing pass is needed. Each item walks the whole
// table through one shared compare unit, one entry per cycle: a read per entry from the
// memory port, then a drain of the read register, then the decision and write-back.
// req_i is ready only while the sequencer is idle, which it re-enters in the same cycle
// as the result is raised, so a new item is accepted only once the last has retired.
// rsp_o is a result register, so the next item may start while a result is still
// waiting; a waiting result stalls only the final write-back of the following item.
// An add refreshes a hit entry (offered + node weight, saturating at 65535, and
// time_now) when the offer is shorter or the entry is older than route_timeout; a miss
// takes the lowest free entry, else the oldest one. Write configuration only while no
// item is in flight.
// Depends on drt_pkg, drt_stream_if and drt_scan_unit.
module distance_route_table_unit #(
  parameter int unsigned Entries = drt_pkg::DRT_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [drt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  drt_stream_if.sink                    req_i,
  drt_stream_if.source                  rsp_o
);
  import drt_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  typedef enum logic [1:0] {StIdle, StScan, StDrain, StDone} state_e;

  state_e              state_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic                cmp_vld_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic                cmp_ent_vld_q;
  req_t                req_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [TIME_W-1:0]   timeout_q;
  logic [Entries-1:0]  valid_q;
  logic                rsp_vld_q;
  rsp_t                rsp_q;

  // Route memory: one write and one registered read per cycle
  entry_t              mem_q [Entries];
  entry_t              rd_data_q;

  scan_t               scan;
  logic [IdxW-1:0]     hit_idx;
  logic [IdxW-1:0]     free_idx;
  logic [IdxW-1:0]     old_idx;

  logic                accept;
  logic                fire;
  logic [DIST_W:0]     sum;
  logic [DIST_W-1:0]   sat_dist;
  logic [TIME_W-1:0]   age;
  logic                refresh;
  logic [IdxW-1:0]     victim;
  logic                wr_en;
  logic                claim;
  logic [IdxW-1:0]     wr_idx;
  logic [DIST_W-1:0]   res_dist;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;

  drt_scan_unit #(
    .IdxW (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (accept),
    .step_i     (cmp_vld_q),
    .idx_i      (cmp_idx_q),
    .ent_vld_i  (cmp_ent_vld_q),
    .ent_i      (rd_data_q),
    .key_i      (req_q.address),
    .res_o      (scan),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .old_idx_o  (old_idx)
  );

  // Decide the write-back and the result once the walk is over.
  always_comb begin
    sum      = {1'b0, req_q.offered_distance} + (DIST_W + 1)'(weight_q);
    sat_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    age      = req_q.time_now - scan.hit_stamp;
    refresh  = (req_q.offered_distance < scan.hit_dist) || (age > timeout_q);
    victim   = scan.free_found ? free_idx : old_idx;
    wr_en    = 1'b0;
    claim    = 1'b0;
    wr_idx   = hit_idx;
    res_dist = DIST_MAX;
    if (req_q.action == ACT_ADD) begin
      if (scan.hit) begin
        wr_en    = refresh;
        res_dist = refresh ? sat_dist : scan.hit_dist;
      end else begin
        wr_en    = 1'b1;
        claim    = 1'b1;
        wr_idx   = victim;
        res_dist = sat_dist;
      end
    end else if (scan.hit) begin
      res_dist = scan.hit_dist;
    end
  end

  // Retire only when the result register is free or being drained.
  assign fire = (state_q == StDone) && (!rsp_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      mem_q[wr_idx] <= '{address: req_q.address, distance: sat_dist,
                         stamp: req_q.time_now};
    end
    rd_data_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      rd_idx_q      <= '0;
      cmp_vld_q     <= 1'b0;
      cmp_idx_q     <= '0;
      cmp_ent_vld_q <= 1'b0;
      req_q         <= '0;
      weight_q      <= '0;
      timeout_q     <= ROUTE_TIMEOUT_DEFAULT;
      valid_q       <= '0;
      rsp_vld_q     <= 1'b0;
      rsp_q         <= '0;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_WEIGHT:   weight_q  <= cfg_wdata_i[WEIGHT_W-1:0];
          CFG_ROUTE_TIMEOUT: timeout_q <= cfg_wdata_i[TIME_W-1:0];
          default: ;
        endcase
      end

      // Feed the compare unit through registers, in step with the registered memory read
      cmp_vld_q     <= (state_q == StScan);
      cmp_idx_q     <= rd_idx_q;
      cmp_ent_vld_q <= valid_q[rd_idx_q];

      // Raise the result on retire, drop it once taken
      if (fire) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            req_q    <= req_i.data;
            rd_idx_q <= '0;
            state_q  <= StScan;
          end
        end
        StScan: begin
          // Advance the read address; stop after the last entry
          if (rd_idx_q == LastIdx) begin
            state_q <= StDrain;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
        StDrain: begin
          state_q <= StDone;
        end
        StDone: begin
          if (fire) begin
            if (claim) begin
              valid_q[wr_idx] <= 1'b1;
            end
            rsp_q.found    <= scan.hit;
            rsp_q.distance <= res_dist;
            state_q        <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

endmodule

// ===== rtl/drt_checker.sv =====
// Port-level checks of the distance route table, bound to the top level.
// Depends on drt_pkg and distance_route_table_unit_defines.svh.
`include "distance_route_table_unit_defines.svh"

module drt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input drt_pkg::rsp_t rsp_data_i
);
  import drt_pkg::*;

  // A taken item keeps the block busy for the next cycle.
  `DRT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // A new result only appears out of a busy cycle.
  `DRT_ASSERT_IMP(a_rsp_from_busy, clk_i, rst_ni, $rose(rsp_valid_i), !$past(req_ready_i))

  // A stalled result stays put.
  `DRT_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i))

endmodule

bind distance_route_table_unit drt_checker u_drt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for distance_route_table_unit: directed and random route items.
// Depends on drt_pkg and drt_stream_if; predicts each result with its own copy of the table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import drt_pkg::*;

  localparam int unsigned ENTRIES     = DRT_ENTRIES;
  localparam int unsigned POOL_SIZE   = 24;      // more addresses than entries forces evictions
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 2 * (ENTRIES + 3);
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [ADDR_W-1:0] FILL_BASE = 48'h1000_0000_0000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  drt_stream_if #(.T(req_t)) req_if ();
  drt_stream_if #(.T(rsp_t)) rsp_if ();

  distance_route_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Predicted route table and register copies.
  logic                tbl_valid [ENTRIES];
  logic [ADDR_W-1:0]   tbl_addr  [ENTRIES];
  logic [DIST_W-1:0]   tbl_dist  [ENTRIES];
  logic [TIME_W-1:0]   tbl_stamp [ENTRIES];
  logic [WEIGHT_W-1:0] model_weight;
  logic [TIME_W-1:0]   model_timeout;

  rsp_t              expected_routes_q [$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [TIME_W-1:0] route_clock;

  bit          sender_idle_en;
  bit          sink_stall_en;
  int unsigned hold_cycles;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned adds_sent;
  int unsigned lookups_sent;
  int unsigned hits_predicted;
  int unsigned evictions;
  int unsigned settings_count;

  // Free-running clock, 12 ns period.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: stop a hung run with a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, expected_routes_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: drive ready at the falling edge. A pending hold-off keeps ready low
  // for a counted number of cycles so the block fills up and stalls its input.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready = !(sink_stall_en && $urandom_range(99) < 27);
      end
    end
  end

  // Result checker: compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (expected_routes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result at cycle %0d: found=%0b distance=%0d",
                   cycle_count, rsp_if.data.found, rsp_if.data.distance);
      end else begin
        want = expected_routes_q.pop_front();
        if (rsp_if.data.found !== want.found || rsp_if.data.distance !== want.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on result %0d: found exp %0b got %0b, distance exp %0d got %0d",
                     results_seen, want.found, rsp_if.data.found,
                     want.distance, rsp_if.data.distance);
        end
      end
    end
  end

  // Clear the predicted table and load reset register values.
  function automatic void reset_route_model();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i]  = '0;
      tbl_dist[i]  = '0;
      tbl_stamp[i] = '0;
    end
    model_weight  = '0;
    model_timeout = ROUTE_TIMEOUT_DEFAULT;
  endfunction

  // Apply one item to the predicted table and return the result it must produce.
  function automatic rsp_t predict_route(input req_t item);
    int                hit_idx;
    int                slot;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] new_dist;
    logic [TIME_W-1:0] age;
    rsp_t              res;
    hit_idx = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit_idx < 0 && tbl_valid[i] && tbl_addr[i] == item.address)
        hit_idx = i;
    sum      = {1'b0, item.offered_distance} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, model_weight};
    new_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    res.found = (hit_idx >= 0);
    if (res.found)
      hits_predicted++;
    if (item.action == ACT_ADD) begin
      adds_sent++;
      if (hit_idx >= 0) begin
        slot = hit_idx;
        age  = item.time_now - tbl_stamp[slot];   // wraps modulo 2^32
        if (item.offered_distance < tbl_dist[slot] || age > model_timeout) begin
          tbl_dist[slot]  = new_dist;
          tbl_stamp[slot] = item.time_now;
        end
      end else begin
        // Take the lowest free entry, else the oldest with ties to the lowest index.
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !tbl_valid[i])
            slot = i;
        if (slot < 0) begin
          evictions++;
          slot = 0;
          for (int i = 1; i < ENTRIES; i++)
            if (tbl_stamp[i] < tbl_stamp[slot])
              slot = i;
        end
        tbl_valid[slot] = 1'b1;
        tbl_addr[slot]  = item.address;
        tbl_dist[slot]  = new_dist;
        tbl_stamp[slot] = item.time_now;
      end
      res.distance = tbl_dist[slot];
    end else begin
      lookups_sent++;
      res.distance = (hit_idx >= 0) ? tbl_dist[hit_idx] : DIST_MAX;
    end
    return res;
  endfunction

  function automatic req_t route_item(input logic act, input logic [ADDR_W-1:0] addr,
                                      input logic [DIST_W-1:0] offer,
                                      input logic [TIME_W-1:0] stamp);
    req_t item;
    item.action           = act;
    item.address          = addr;
    item.offered_distance = offer;
    item.time_now         = stamp;
    return item;
  endfunction

  // Offer one item, optionally after a random gap, and record its prediction once accepted.
  // Valid stays high after acceptance; the next call or a drain changes it at the next
  // falling edge, before the block can be ready again.
  task automatic send_route_item(input req_t item);
    int unsigned gap;
    if (sender_idle_en && $urandom_range(99) < 27) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(24, 5) : $urandom_range(4, 1);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
      end
    end
    @(negedge clk_i);
    req_if.valid = 1'b1;
    req_if.data  = item;
    do @(posedge clk_i); while (!req_if.ready);
    expected_routes_q.insert(expected_routes_q.size(), predict_route(item));
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain_routes();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (expected_routes_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Write one register with the block idle, and mirror it in the predictor.
  task automatic write_route_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
    drain_routes();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_NODE_WEIGHT)
      model_weight = value[WEIGHT_W-1:0];
    else
      model_timeout = value[TIME_W-1:0];
    settings_count++;
  endtask

  // Hits, refresh rules, saturation and the age test, including wrap of the tick counter.
  task automatic test_directed_updates();
    send_route_item(route_item(ACT_LOOKUP, '0, '0, '0));                // empty table
    send_route_item(route_item(ACT_ADD, '0, 16'hFFFF, 32'd100));
    send_route_item(route_item(ACT_ADD, ADDR_ONES, 16'h0000, 32'hFFFF_FFFF));
    send_route_item(route_item(ACT_LOOKUP, ADDR_ONES, 16'h1234, 32'd5));
    send_route_item(route_item(ACT_ADD, '0, 16'd10, 32'd200));          // shorter offer
    send_route_item(route_item(ACT_ADD, '0, 16'd20, 32'd300));          // longer and fresh
    write_route_reg(CFG_NODE_WEIGHT, 32'd255);
    write_route_reg(CFG_ROUTE_TIMEOUT, 32'd100);
    send_route_item(route_item(ACT_ADD, '0, 16'd500, 32'd300));         // age equals timeout
    send_route_item(route_item(ACT_ADD, '0, 16'd500, 32'd301));         // age past timeout
    send_route_item(route_item(ACT_ADD, 48'd5, 16'hFFFF, 32'd400));     // miss, saturates
    send_route_item(route_item(ACT_ADD, 48'd5, 16'd65400, 32'd401));    // hit, saturates
    send_route_item(route_item(ACT_ADD, ADDR_ONES, 16'd900, 32'd200));  // age wraps past zero
  endtask

  // Fill the table, then miss: the oldest entry goes, the lower of two equal stamps first.
  task automatic test_directed_eviction();
    logic [TIME_W-1:0] stamp;
    for (int i = 3; i < ENTRIES; i++) begin
      stamp = (i == 3 || i == 5) ? 32'd7 : (i == 4) ? 32'd50 : 32'd1000 + i;
      send_route_item(route_item(ACT_ADD, FILL_BASE + i, 16'(i * 100), stamp));
    end
    send_route_item(route_item(ACT_ADD, 48'h0000_ABCD_EF01, 16'd42, 32'd2000));
    send_route_item(route_item(ACT_LOOKUP, FILL_BASE + 3, '0, 32'd2001));
    send_route_item(route_item(ACT_LOOKUP, FILL_BASE + 5, '0, 32'd2002));
  endtask

  // Random adds and lookups over a small address pool, with a drifting tick counter.
  task automatic test_random_routes(input int n_items, input int unsigned time_step,
                                    input bit drain_pauses);
    req_t        item;
    int unsigned pick;
    for (int k = 0; k < n_items; k++) begin
      item.action  = ($urandom_range(99) < 35) ? ACT_LOOKUP : ACT_ADD;
      item.address = ($urandom_range(99) < 88) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
                                               : ADDR_W'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 30)
        item.offered_distance = DIST_W'($urandom_range(60));
      else if (pick < 42)
        item.offered_distance = DIST_W'(DIST_MAX - $urandom_range(300));
      else
        item.offered_distance = DIST_W'($urandom);
      if ($urandom_range(99) < 4)
        route_clock = $urandom;
      else
        route_clock += $urandom_range(time_step);
      item.time_now = route_clock;
      send_route_item(item);
      if (drain_pauses && $urandom_range(99) < 6)
        drain_routes();
    end
  endtask

  // Hold the result side off while items keep coming so the input stalls.
  task automatic test_result_backpressure();
    drain_routes();
    @(posedge clk_i);
    hold_cycles = 200;
    test_random_routes(24, 500, 1'b0);
  endtask

  // Back-to-back items with no idling on either side.
  task automatic test_back_to_back();
    drain_routes();
    sender_idle_en = 1'b0;
    sink_stall_en  = 1'b0;
    test_random_routes(100, 3, 1'b0);
    sender_idle_en = 1'b1;
    sink_stall_en  = 1'b1;
  endtask

  initial begin
    int unsigned rand_timeout;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    sender_idle_en = 1'b1;
    sink_stall_en  = 1'b1;
    hold_cycles    = 0;
    cycle_count    = 0;
    mismatches     = 0;
    results_seen   = 0;
    adds_sent      = 0;
    lookups_sent   = 0;
    hits_predicted = 0;
    evictions      = 0;
    settings_count = 0;
    reset_route_model();
    route_clock = $urandom;
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_ONES;
    for (int i = 2; i < POOL_SIZE; i++)
      addr_pool[i] = ADDR_W'({$urandom, $urandom});

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_updates();
    test_directed_eviction();

    // Small weight, short timeout: ages cross the limit regularly.
    write_route_reg(CFG_NODE_WEIGHT, 32'd3);
    write_route_reg(CFG_ROUTE_TIMEOUT, 32'd5000);
    test_random_routes(160, 700, 1'b0);

    // Zero timeout: any nonzero age refreshes.
    write_route_reg(CFG_NODE_WEIGHT, 32'd0);
    write_route_reg(CFG_ROUTE_TIMEOUT, 32'd0);
    test_back_to_back();

    // Largest timeout: only shorter offers refresh.
    write_route_reg(CFG_NODE_WEIGHT, 32'd254);
    write_route_reg(CFG_ROUTE_TIMEOUT, 32'hFFFF_FFFF);
    test_result_backpressure();
    test_random_routes(80, 32'h1000_0000, 1'b0);

    // Default timeout, with the sender pausing until everything is back.
    write_route_reg(CFG_NODE_WEIGHT, 32'($urandom_range(255)));
    write_route_reg(CFG_ROUTE_TIMEOUT, 32'(ROUTE_TIMEOUT_DEFAULT));
    test_random_routes(160, 150000, 1'b1);

    rand_timeout = $urandom_range(20000, 200);
    write_route_reg(CFG_NODE_WEIGHT, 32'($urandom_range(255)));
    write_route_reg(CFG_ROUTE_TIMEOUT, rand_timeout);
    test_random_routes(160, rand_timeout / 6 + 1, 1'b0);

    drain_routes();
    repeat (SETTLE) @(posedge clk_i);

    $display("Covered %0d adds and %0d lookups (%0d hits, %0d evictions of the oldest route)",
             adds_sent, lookups_sent, hits_predicted, evictions);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             settings_count, results_seen, mismatches);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/drt_pkg.sv
rtl/drt_stream_if.sv
rtl/drt_scan_unit.sv
rtl/distance_route_table_unit.sv
rtl/drt_checker.sv
dv/tb_top.sv
